### src/ddv_pkg.sv
// ----------------------------------------------------------------------------
// ddv_pkg
// shared types and codes for the delta-of-delta varint decoder
// ----------------------------------------------------------------------------
package ddv_pkg;

	localparam int VALUE_W = 64;
	localparam int COUNT_W = 31;

	// token kinds passed from the front part to the back part
	localparam logic [1:0] KIND_HDR   = 2'd0;
	localparam logic [1:0] KIND_FIRST = 2'd1;
	localparam logic [1:0] KIND_DOD   = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VALUE_W-1:0] payload;
		logic               commit;
		logic               final_value;
		logic               truncated;
	} token_t;

	function automatic logic [VALUE_W-1:0] unzigzag(input logic [VALUE_W-1:0] n);
		return (n >> 1) ^ {VALUE_W{n[0]}};
	endfunction

endpackage

### src/ddv_in_if.sv
// ----------------------------------------------------------------------------
// ddv_in_if
// byte channel into the decoder, valid/ready handshake
// ----------------------------------------------------------------------------
interface ddv_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        block_start;
	logic [30:0] value_count;
	logic        buffer_end;

	modport source (output valid, data_byte, block_start, value_count, buffer_end,
		input ready);
	modport sink (input valid, data_byte, block_start, value_count, buffer_end,
		output ready);
endinterface

### src/ddv_out_if.sv
// ----------------------------------------------------------------------------
// ddv_out_if
// decoded value channel out of the decoder, valid/ready handshake
// ----------------------------------------------------------------------------
interface ddv_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] decoded_value;
	logic               final_value;
	logic               truncated;

	modport source (output valid, decoded_value, final_value, truncated, input ready);
	modport sink (input valid, decoded_value, final_value, truncated, output ready);
endinterface

### src/delta_of_delta_varint_decoder.sv
// ----------------------------------------------------------------------------
// delta_of_delta_varint_decoder
// Decodes a delta-of-delta zigzag varint column, one byte per word. A word
// with block_start high opens a block and samples value_count; a zero count
// opens nothing. The first eight bytes give a little-endian 64-bit value,
// the next varint the first delta, every later varint a delta-of-delta; all
// sums wrap at 64 bits and varint bits past bit 63 are dropped. The last
// counted value carries final_value. If buffer_end arrives while values are
// still owed, one result is sent with final_value and truncated set, holding
// the partly built value, and the block closes. Bytes outside a block are
// dropped. The block takes one byte per clock whatever the byte kind, while
// the token queue has room. The parser pushes a token into the queue at the
// accepting edge for the byte that completes a result; the running delta add
// then fills the delta stage register and the running value add the value
// register that drives the result port. The queue lets the parser keep
// taking bytes for QUEUE_DEPTH tokens while the result side is stalled.
// ----------------------------------------------------------------------------
module delta_of_delta_varint_decoder import ddv_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	ddv_in_if.sink    stream,
	ddv_out_if.source result
);

	// parser to queue
	token_t front_tok;
	logic   front_valid;
	logic   front_ready;

	// queue to value builder
	token_t back_tok;
	logic   back_valid;
	logic   back_ready;

	// front part: classifies each byte, builds header and varint words
	ddv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.tok       (front_tok),
		.tok_valid (front_valid),
		.tok_ready (front_ready)
	);

	// token queue decoupling the two sides
	ddv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tok    (front_tok),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_tok   (back_tok),
		.out_valid (back_valid),
		.out_ready (back_ready)
	);

	// back part: delta and value accumulation, output register
	ddv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (back_tok),
		.tok_valid (back_valid),
		.tok_ready (back_ready),
		.result    (result)
	);

	// a truncated token always closes its block
	assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && front_tok.truncated) |-> front_tok.final_value)
	else $error("truncated token without final flag");

	// a stalled result freezes the value builder, so the queue holds its head
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !back_ready)
	else $error("value builder advanced under a stalled result");

	// a byte is taken only when its token has room in the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.ready) |-> front_ready)
	else $error("byte accepted with the queue full");

endmodule

### src/ddv_front.sv
// ----------------------------------------------------------------------------
// ddv_front
// byte parser: header assembly, varint gathering, value counting
// ----------------------------------------------------------------------------
module ddv_front import ddv_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ddv_in_if.sink stream,
	output token_t tok,
	output logic   tok_valid,
	input  logic   tok_ready
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_FIRST  = 2'd2;
	localparam logic [1:0] PH_DOD    = 2'd3;

	logic [1:0]         phase_q, phase_e, phase_d;
	logic [2:0]         idx_q, idx_e, idx_d;
	logic [VALUE_W-1:0] hv_q, hv_e, hv_n, hv_d;
	logic [VALUE_W-1:0] acc_q, acc_e, acc_n, acc_d;
	logic [6:0]         sh_q, sh_e, sh_n, sh_d;
	logic [COUNT_W-1:0] vr_q, vr_e, vr_dec, vr_d;
	logic               start, done, last, emit, accept;

	assign start  = stream.block_start;
	assign accept = stream.valid && stream.ready;
	assign stream.ready = tok_ready;

	always_comb begin
		// a start word resets the block before this byte is parsed
		phase_e = start ? ((stream.value_count != '0) ? PH_HEADER : PH_IDLE) : phase_q;
		vr_e    = start ? stream.value_count : vr_q;
		idx_e   = start ? 3'd0 : idx_q;
		hv_e    = start ? '0 : hv_q;
		acc_e   = start ? '0 : acc_q;
		sh_e    = start ? 7'd0 : sh_q;

		hv_n  = hv_e | (VALUE_W'(stream.data_byte) << {idx_e, 3'b000});
		// payload bits at position 64 and above fall away
		acc_n = sh_e[6] ? acc_e : (acc_e | (VALUE_W'(stream.data_byte[6:0]) << sh_e[5:0]));
		sh_n  = (stream.data_byte[7] && !sh_e[6]) ? sh_e + 7'd7 : sh_e;

		unique case (phase_e)
			PH_IDLE:   done = 1'b0;
			PH_HEADER: done = (idx_e == 3'd7);
			default:   done = !stream.data_byte[7];
		endcase

		vr_dec = vr_e - COUNT_W'(1);
		last   = done && (vr_dec == '0);
		emit   = (phase_e != PH_IDLE) && (done || stream.buffer_end);

		tok.kind        = (phase_e == PH_HEADER) ? KIND_HDR :
			((phase_e == PH_FIRST) ? KIND_FIRST : KIND_DOD);
		tok.payload     = (phase_e == PH_HEADER) ? hv_n : unzigzag(acc_n);
		tok.commit      = done;
		tok.final_value = last || stream.buffer_end;
		tok.truncated   = stream.buffer_end && !last;

		phase_d = phase_e;
		idx_d   = idx_e;
		hv_d    = hv_e;
		acc_d   = acc_e;
		sh_d    = sh_e;
		vr_d    = vr_e;
		priority if (phase_e == PH_HEADER) begin
			hv_d = hv_n;
			if (done) begin
				vr_d    = vr_dec;
				phase_d = last ? PH_IDLE : PH_FIRST;
				idx_d   = 3'd0;
				acc_d   = '0;
				sh_d    = 7'd0;
			end else begin
				idx_d = idx_e + 3'd1;
			end
		end else if (phase_e != PH_IDLE) begin
			if (done) begin
				vr_d    = vr_dec;
				phase_d = last ? PH_IDLE : PH_DOD;
				acc_d   = '0;
				sh_d    = 7'd0;
			end else begin
				acc_d = acc_n;
				sh_d  = sh_n;
			end
		end else begin
			phase_d = PH_IDLE;
		end
		if (stream.buffer_end) begin
			phase_d = PH_IDLE;
		end
	end

	assign tok_valid = stream.valid && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= 3'd0;
			hv_q    <= '0;
			acc_q   <= '0;
			sh_q    <= 7'd0;
			vr_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			hv_q    <= hv_d;
			acc_q   <= acc_d;
			sh_q    <= sh_d;
			vr_q    <= vr_d;
		end
	end

endmodule

### src/ddv_queue.sv
// ----------------------------------------------------------------------------
// ddv_queue
// small token fifo between the parser and the value builder
// ----------------------------------------------------------------------------
module ddv_queue import ddv_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  token_t in_tok,
	input  logic   in_valid,
	output logic   in_ready,
	output token_t out_tok,
	output logic   out_valid,
	input  logic   out_ready
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	token_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### src/ddv_back.sv
// ----------------------------------------------------------------------------
// ddv_back
// value builder: running delta stage, running value stage, output register
// ----------------------------------------------------------------------------
module ddv_back import ddv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  token_t    tok,
	input  logic      tok_valid,
	output logic      tok_ready,
	ddv_out_if.source result
);

	logic               en;
	logic [VALUE_W-1:0] rd_q, rv_q;
	logic [VALUE_W-1:0] delta_c, val_c;

	logic               v_s1, commit_s1, final_s1, trunc_s1;
	logic [1:0]         kind_s1;
	logic [VALUE_W-1:0] payload_s1, delta_s1;

	logic               v_s2, final_s2, trunc_s2;
	logic [VALUE_W-1:0] value_s2;

	assign en        = !v_s2 || result.ready;
	assign tok_ready = en;

	assign delta_c = (tok.kind == KIND_FIRST) ? tok.payload : rd_q + tok.payload;
	assign val_c   = (kind_s1 == KIND_HDR) ? payload_s1 : rv_q + delta_s1;

	always_ff @(posedge clk) begin
		if (en && tok_valid) begin
			kind_s1    <= tok.kind;
			payload_s1 <= tok.payload;
			delta_s1   <= delta_c;
			commit_s1  <= tok.commit;
			final_s1   <= tok.final_value;
			trunc_s1   <= tok.truncated;
		end
		if (en && v_s1) begin
			value_s2 <= val_c;
			final_s2 <= final_s1;
			trunc_s2 <= trunc_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rd_q <= '0;
			rv_q <= '0;
		end else if (en) begin
			v_s1 <= tok_valid;
			v_s2 <= v_s1;
			// delta is kept only for completed varints
			if (tok_valid && tok.commit && (tok.kind != KIND_HDR)) begin
				rd_q <= delta_c;
			end
			if (v_s1 && commit_s1) begin
				rv_q <= val_c;
			end
		end
	end

	assign result.valid         = v_s2;
	assign result.decoded_value = value_s2;
	assign result.final_value   = final_s2;
	assign result.truncated     = trunc_s2;

endmodule
